### hdl/fstx_pkg.sv
// Package for the float-to-short-decimal-text formatter.
// Holds widths, ASCII codes, item types and the eighths digit table.
// No dependencies.
package fstx_pkg;

    // Widths
    localparam int FSTX_FLOAT_W    = 32;
    localparam int FSTX_MANT_W     = 24;
    localparam int FSTX_CHAR_W     = 7;
    localparam int FSTX_IP_W       = 19;  // integer part, exponent at most 18
    localparam int FSTX_BIN_W      = 21;  // padded so three stages of seven steps cover it
    localparam int FSTX_DIGITS     = 6;   // decimal digits of the integer part
    localparam int FSTX_BCD_W      = 4 * FSTX_DIGITS;
    localparam int FSTX_DAB_STEPS  = 7;   // shift-add-3 steps per pipeline stage
    localparam int FSTX_TEXT_MAX   = 7;
    localparam int FSTX_LEN_W      = 3;
    localparam int FSTX_FRAC_W     = 3;

    // Exponent handling
    localparam logic [7:0]        FSTX_EXP_BIAS   = 8'd127;
    localparam logic signed [7:0] FSTX_EXP_MAX    = 8'sd18;
    localparam logic signed [7:0] FSTX_EXP_MIN    = -8'sd3;
    localparam logic [7:0]        FSTX_MANT_POINT = 8'd23;
    localparam logic [7:0]        FSTX_FRAC_POINT = 8'd20;
    localparam logic [FSTX_MANT_W-1:0] FSTX_MANT_ONE = 24'h800000;

    // Length limits
    localparam logic [FSTX_LEN_W-1:0] FSTX_INT_MAX = 3'd5;  // point added up to this

    // ASCII codes
    localparam logic [FSTX_CHAR_W-1:0] FSTX_CH_ZERO  = 7'h30;
    localparam logic [FSTX_CHAR_W-1:0] FSTX_CH_MINUS = 7'h2D;
    localparam logic [FSTX_CHAR_W-1:0] FSTX_CH_POINT = 7'h2E;
    localparam logic [FSTX_CHAR_W-1:0] FSTX_CH_UP_I  = 7'h49;
    localparam logic [FSTX_CHAR_W-1:0] FSTX_CH_LO_N  = 7'h6E;
    localparam logic [FSTX_CHAR_W-1:0] FSTX_CH_LO_F  = 7'h66;

    typedef enum logic [1:0] {
        FSTX_KIND_NUM,
        FSTX_KIND_INF,
        FSTX_KIND_ZERO
    } fstx_kind_t;

    // One item as it moves through the conversion stages
    typedef struct packed {
        fstx_kind_t                kind;
        logic                      neg;
        logic [FSTX_FRAC_W-1:0]    frac;
        logic [FSTX_BCD_W-1:0]     bcd;
        logic [FSTX_BIN_W-1:0]     bin;
    } fstx_work_t;

    // Finished text, character 0 first
    typedef struct packed {
        logic [FSTX_TEXT_MAX-1:0][FSTX_CHAR_W-1:0] chars;
        logic [FSTX_LEN_W-1:0]                     len;
    } fstx_text_t;

    // Digit j (0..2) of the eighths text: 000 125 250 375 500 625 750 875
    function automatic logic [3:0] fstx_eighth_digit(input logic [FSTX_FRAC_W-1:0] frac,
                                                     input logic [1:0] j);
        logic [11:0] row;
        begin
            unique case (frac)
                3'd0: row = 12'h000;
                3'd1: row = 12'h125;
                3'd2: row = 12'h250;
                3'd3: row = 12'h375;
                3'd4: row = 12'h500;
                3'd5: row = 12'h625;
                3'd6: row = 12'h750;
                3'd7: row = 12'h875;
                default: row = 12'h000;
            endcase
            unique case (j)
                2'd0:    fstx_eighth_digit = row[11:8];
                2'd1:    fstx_eighth_digit = row[7:4];
                default: fstx_eighth_digit = row[3:0];
            endcase
        end
    endfunction

    // Digits left of the eighths text once trailing zeros are gone
    function automatic logic [1:0] fstx_eighth_sig(input logic [FSTX_FRAC_W-1:0] frac);
        begin
            unique case (frac)
                3'd0:       fstx_eighth_sig = 2'd0;
                3'd4:       fstx_eighth_sig = 2'd1;
                3'd2, 3'd6: fstx_eighth_sig = 2'd2;
                default:    fstx_eighth_sig = 2'd3;
            endcase
        end
    endfunction

endpackage

### hdl/fstx_dabble_stage.sv
// One pipeline stage of the binary-to-BCD conversion (seven shift-add-3 steps).
// Depends on fstx_pkg.
module fstx_dabble_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fstx_pkg::fstx_work_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fstx_pkg::fstx_work_t out_data
);

    logic                 valid_reg;
    fstx_pkg::fstx_work_t data_reg;
    fstx_pkg::fstx_work_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next = in_data;
        for (int s = 0; s < fstx_pkg::FSTX_DAB_STEPS; s++)
        begin
            for (int d = 0; d < fstx_pkg::FSTX_DIGITS; d++)
            begin
                if (data_next.bcd[d*4 +: 4] >= 4'd5)
                begin
                    data_next.bcd[d*4 +: 4] = data_next.bcd[d*4 +: 4] + 4'd3;
                end
            end
            {data_next.bcd, data_next.bin} =
                {data_next.bcd[fstx_pkg::FSTX_BCD_W-2:0], data_next.bin, 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### hdl/fstx_text_build.sv
// Builds the character string and its length from a converted item.
// Depends on fstx_pkg.
module fstx_text_build
(
    input  fstx_pkg::fstx_work_t item,
    output fstx_pkg::fstx_text_t text
);

    logic [3:0]                      digs [8];
    logic [fstx_pkg::FSTX_LEN_W-1:0] nd;
    logic [fstx_pkg::FSTX_LEN_W-1:0] pos;
    logic [fstx_pkg::FSTX_LEN_W-1:0] int_len;
    logic [fstx_pkg::FSTX_LEN_W-1:0] avail;
    logic [1:0]                      sig;
    logic [1:0]                      kept;
    logic [fstx_pkg::FSTX_LEN_W-1:0] p3;
    logic [fstx_pkg::FSTX_LEN_W-1:0] di;
    logic [fstx_pkg::FSTX_LEN_W-1:0] fj;

    always_comb
    begin
        for (int k = 0; k < fstx_pkg::FSTX_DIGITS; k++)
        begin
            digs[k] = item.bcd[k*4 +: 4];
        end
        digs[6] = 4'd0;
        digs[7] = 4'd0;

        // significant digits, at least one
        nd = 3'd1;
        for (int k = 1; k < fstx_pkg::FSTX_DIGITS; k++)
        begin
            if (digs[k] != 4'd0)
            begin
                nd = 3'(k + 1);
            end
        end

        pos     = item.neg ? 3'd1 : 3'd0;
        int_len = pos + nd;

        // fraction slots left after the point; at most three fraction digits are kept
        avail = 3'(fstx_pkg::FSTX_TEXT_MAX - 1) - int_len;
        sig   = fstx_pkg::fstx_eighth_sig(item.frac);
        if (int_len > fstx_pkg::FSTX_INT_MAX)
        begin
            kept = 2'd0;
        end
        else if ({1'b0, sig} < avail)
        begin
            kept = sig;
        end
        else
        begin
            kept = avail[1:0];
        end

        text.len = (kept != 2'd0) ? int_len + 3'd1 + {1'b0, kept} : int_len;

        for (int p = 0; p < fstx_pkg::FSTX_TEXT_MAX; p++)
        begin
            p3 = 3'(p);
            di = nd - 3'd1 - (p3 - pos);
            fj = p3 - int_len - 3'd1;
            if (p3 < pos)
            begin
                text.chars[p] = fstx_pkg::FSTX_CH_MINUS;
            end
            else if (p3 < int_len)
            begin
                text.chars[p] = fstx_pkg::FSTX_CH_ZERO | {3'b000, digs[di]};
            end
            else if (p3 == int_len)
            begin
                text.chars[p] = fstx_pkg::FSTX_CH_POINT;
            end
            else
            begin
                text.chars[p] = fstx_pkg::FSTX_CH_ZERO |
                    {3'b000, fstx_pkg::fstx_eighth_digit(item.frac, fj[1:0])};
            end
        end

        unique case (item.kind)
            fstx_pkg::FSTX_KIND_INF:
            begin
                text.chars[0] = fstx_pkg::FSTX_CH_UP_I;
                text.chars[1] = fstx_pkg::FSTX_CH_LO_N;
                text.chars[2] = fstx_pkg::FSTX_CH_LO_F;
                text.len      = 3'd3;
            end
            fstx_pkg::FSTX_KIND_ZERO:
            begin
                text.chars[0] = fstx_pkg::FSTX_CH_ZERO;
                text.len      = 3'd1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

### hdl/float_to_short_decimal_text.sv
// Top level of the float-to-short-decimal-text formatter.
// Depends on fstx_pkg, fstx_dabble_stage and fstx_text_build.
//
//   channel  | ports                            | transfer
//   ---------+----------------------------------+------------------------------
//   input    | start, busy, float_bits          | edge with start high, busy low
//   result   | text_valid, text_char, is_last   | edge ending a text_valid cycle
//
// An input goes through a decode/shift stage and three BCD stages (seven
// shift-add-3 steps each); the text is built as it enters the output shifter.
// The first character appears once the item has passed the decode register,
// the three BCD stage registers and the output shifter; the rest follow one
// per cycle, and a text holds 1 to 7 characters. The one-character-per-cycle
// output shifter sets the sustained rate; when it is full the stages hold and
// busy rises once the decode stage is held. Reset (rst_n low, asynchronous)
// empties every stage and the shifter; results cannot be stalled.
module float_to_short_decimal_text
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] float_bits,
    output logic        text_valid,
    output logic [6:0]  text_char,
    output logic        is_last
);

    // ------------------------------------------------------------------
    // Decode stage: exponent, special cases, integer and eighths fields
    // ------------------------------------------------------------------
    logic                                 accept;
    logic [7:0]                           exp_unb;
    logic [fstx_pkg::FSTX_MANT_W-1:0]     mant;
    logic [4:0]                           shift_int;
    logic [4:0]                           shift_frac;
    logic [fstx_pkg::FSTX_IP_W-1:0]       ip_bin;
    fstx_pkg::fstx_work_t                 s1_next;
    fstx_pkg::fstx_work_t                 s1_reg;
    logic                                 s1_valid_reg;
    logic                                 s1_ready;

    assign exp_unb    = float_bits[30:23] - fstx_pkg::FSTX_EXP_BIAS;
    assign mant       = fstx_pkg::FSTX_MANT_ONE | {1'b0, float_bits[22:0]};
    // both shifts matter only for exponents -3..18; other items ignore them
    assign shift_int  = 5'(fstx_pkg::FSTX_MANT_POINT - exp_unb);
    assign shift_frac = 5'(fstx_pkg::FSTX_FRAC_POINT - exp_unb);
    assign ip_bin     = fstx_pkg::FSTX_IP_W'(mant >> shift_int);

    always_comb
    begin
        s1_next.neg  = float_bits[31];
        s1_next.frac = fstx_pkg::FSTX_FRAC_W'(mant >> shift_frac);
        s1_next.bcd  = '0;
        s1_next.bin  = fstx_pkg::FSTX_BIN_W'(ip_bin);
        priority if ($signed(exp_unb) > fstx_pkg::FSTX_EXP_MAX)
        begin
            s1_next.kind = fstx_pkg::FSTX_KIND_INF;
        end
        else if ($signed(exp_unb) < fstx_pkg::FSTX_EXP_MIN)
        begin
            s1_next.kind = fstx_pkg::FSTX_KIND_ZERO;
        end
        else
        begin
            s1_next.kind = fstx_pkg::FSTX_KIND_NUM;
        end
    end

    // ------------------------------------------------------------------
    // BCD conversion: three stages
    // ------------------------------------------------------------------
    logic                 s2_in_ready;
    logic                 s2_valid;
    fstx_pkg::fstx_work_t s2_data;
    logic                 s3_in_ready;
    logic                 s3_valid;
    fstx_pkg::fstx_work_t s3_data;
    logic                 s4_in_ready;
    logic                 s4_valid;
    fstx_pkg::fstx_work_t s4_data;
    logic                 ser_take;

    assign s1_ready = !s1_valid_reg || s2_in_ready;
    assign busy     = !s1_ready;
    assign accept   = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    fstx_dabble_stage u_dab0
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_ready  (s2_in_ready),
        .in_data   (s1_reg),
        .out_valid (s2_valid),
        .out_ready (s3_in_ready),
        .out_data  (s2_data)
    );

    fstx_dabble_stage u_dab1
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s3_in_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s4_in_ready),
        .out_data  (s3_data)
    );

    fstx_dabble_stage u_dab2
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid),
        .in_ready  (s4_in_ready),
        .in_data   (s3_data),
        .out_valid (s4_valid),
        .out_ready (ser_take),
        .out_data  (s4_data)
    );

    // ------------------------------------------------------------------
    // Text assembly and output shifter
    // ------------------------------------------------------------------
    fstx_pkg::fstx_text_t built;

    fstx_text_build u_build
    (
        .item (s4_data),
        .text (built)
    );

    logic [fstx_pkg::FSTX_TEXT_MAX-1:0][fstx_pkg::FSTX_CHAR_W-1:0] ser_chars_reg;
    logic [fstx_pkg::FSTX_LEN_W-1:0]                               ser_rem_reg;
    logic                                                          ser_load;

    // shifter is free when empty or on its last character
    assign ser_take = (ser_rem_reg == 3'd0) || (ser_rem_reg == 3'd1);
    assign ser_load = s4_valid && ser_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_rem_reg <= '0;
        end
        else if (ser_load)
        begin
            ser_rem_reg <= built.len;
        end
        else if (ser_rem_reg != 3'd0)
        begin
            ser_rem_reg <= ser_rem_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_load)
        begin
            ser_chars_reg <= built.chars;
        end
        else
        begin
            ser_chars_reg <= {fstx_pkg::FSTX_CHAR_W'(0),
                              ser_chars_reg[fstx_pkg::FSTX_TEXT_MAX-1:1]};
        end
    end

    assign text_valid = (ser_rem_reg != 3'd0);
    assign text_char  = ser_chars_reg[0];
    assign is_last    = (ser_rem_reg == 3'd1);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // a text, once started, continues every cycle until its last character
    a_text_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (text_valid && !is_last) |=> text_valid)
        else $error("text broke off before its last character");

    // a held decode stage keeps its item
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_in_ready) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("decode stage lost or changed a held item");

    // trailing point is always stripped
    a_no_last_point: assert property (@(posedge clk) disable iff (!rst_n)
        (text_valid && (text_char == fstx_pkg::FSTX_CH_POINT)) |-> !is_last)
        else $error("text ends in a bare point");

    // busy only when an item waits in the decode stage
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (s1_valid_reg && s2_valid))
        else $error("busy without a held item");

endmodule
